>>> rtl/dac_pkg.sv
// ============================================================================
// dac_pkg : shared definitions of the drained area accumulation core
// Grid limits, derived widths, function and register codes, the command and
// status bundles between controller and datapath, and the cell address map.
// ============================================================================
package dac_pkg;

    // Grid limits.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int NCELLS   = MAX_ROWS * MAX_COLS;

    // Derived widths.
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int NR_W   = $clog2(MAX_ROWS + 1);
    localparam int NC_W   = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int STEP_W = $clog2(NCELLS + 1);

    // Field widths of the interface.
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 6;
    localparam int ELEV_W    = 16;
    localparam int OFS_W     = 2;
    localparam int DIR_W     = 2 * OFS_W;
    localparam int AREA_W    = 28;
    localparam int CAREA_W   = 16;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Function codes of an input transaction.
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_AREA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd2;

    // Step offset bit patterns; every other pattern counts as zero.
    localparam logic [OFS_W-1:0] OFS_PLUS  = 2'b01;
    localparam logic [OFS_W-1:0] OFS_MINUS = 2'b11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // write elevation and step of the input cell
        logic rd_issue;    // read the area of the input cell
        logic out_rd;      // load the output register with the read area
        logic out_zero;    // load the output register with area zero
        logic run_start;   // latch grid size, clear the cycle flag
        logic clr;         // clear one area entry
        logic scan_issue;  // read the cell at the scan position
        logic start;       // open a trace at the scan cell
        logic step_issue;  // read the downstream cell
        logic set_cycle;   // trace ran too long
        logic upd;         // write the downstream cell and move onto it
        logic advance;     // move the scan position on
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic small_grid;
        logic start_ok;
        logic next_ok;
        logic nxt_sink;
        logic steps_full;
        logic scan_last;
    } t_dp_sts;

    // Row-major cell address.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(int'(r) * MAX_COLS + int'(c));
    endfunction

endpackage

>>> rtl/dac_ram.sv
// ============================================================================
// dac_ram : generic single-clock RAM
// One write port and one read port, read data registered (read before write).
// ============================================================================
module dac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dac_ctrl.sv
// ============================================================================
// dac_ctrl : controller of the drained area accumulation core
// Input and output handshakes and the state machine that sequences loads,
// reads and the accumulation run over the datapath.
// ============================================================================
module dac_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dac_pkg::FUNC_W-1:0]    i_func,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  dac_pkg::t_dp_sts              i_sts,
    output dac_pkg::t_dp_cmd              o_cmd
);
    import dac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CLR,
        S_SCAN,
        S_START,
        S_STEP,
        S_UPD,
        S_ADV,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    accept;
    t_dp_cmd cmd;

    assign o_in_stall = !i_rst_n
                     || !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_func)
                        FUNC_LOAD: begin
                            cmd.load     = 1'b1;
                            cmd.out_zero = 1'b1;
                        end
                        FUNC_RUN: begin
                            cmd.run_start = 1'b1;
                            n_state       = S_CLR;
                        end
                        FUNC_READ: begin
                            cmd.rd_issue = 1'b1;
                            n_state      = S_RD;
                        end
                        default: begin
                            cmd.out_zero = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                cmd.out_rd = 1'b1;
                n_state    = S_IDLE;
            end
            S_CLR: begin
                cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = i_sts.small_grid ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                n_state        = S_START;
            end
            S_START: begin
                if (i_sts.start_ok) begin
                    cmd.start = 1'b1;
                    n_state   = S_STEP;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_STEP: begin
                if (i_sts.next_ok) begin
                    cmd.step_issue = 1'b1;
                    n_state        = S_UPD;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_UPD: begin
                priority if (i_sts.nxt_sink) begin
                    n_state = S_ADV;
                end else if (i_sts.steps_full) begin
                    cmd.set_cycle = 1'b1;
                    n_state       = S_ADV;
                end else begin
                    cmd.upd = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_ADV: begin
                cmd.advance = 1'b1;
                n_state     = i_sts.scan_last ? S_DONE : S_SCAN;
            end
            S_DONE: begin
                cmd.out_zero = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (cmd.out_zero || cmd.out_rd) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

>>> rtl/dac_dpath.sv
// ============================================================================
// dac_dpath : datapath of the drained area accumulation core
// Cell and area memories, configuration registers, scan and trace position,
// area arithmetic with saturation, and the output payload register.
// ============================================================================
module dac_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dac_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [dac_pkg::IDX_W-1:0]         i_row,
    input  logic [dac_pkg::IDX_W-1:0]         i_col,
    input  logic [dac_pkg::ELEV_W-1:0]        i_elevation,
    input  logic signed [dac_pkg::OFS_W-1:0]  i_step_row,
    input  logic signed [dac_pkg::OFS_W-1:0]  i_step_col,
    input  dac_pkg::t_dp_cmd                  i_cmd,
    output dac_pkg::t_dp_sts                  o_sts,
    output logic [dac_pkg::AREA_W-1:0]        o_area,
    output logic                              o_status
);
    import dac_pkg::*;

    // Configuration.
    logic [CAREA_W-1:0] r_cell_area;
    logic [DIM_W-1:0]   r_rows_used;
    logic [DIM_W-1:0]   r_cols_used;

    // Run state.
    logic               r_cycle;
    logic               r_ran;
    logic [NR_W-1:0]    r_nr;
    logic [NC_W-1:0]    r_nc;
    logic [STEP_W-1:0]  r_limit;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [ROW_W-1:0]   r_scan_r;
    logic [COL_W-1:0]   r_scan_c;
    logic [ROW_W-1:0]   r_cur_r;
    logic [COL_W-1:0]   r_cur_c;
    logic [ROW_W-1:0]   r_nxt_r;
    logic [COL_W-1:0]   r_nxt_c;
    logic [DIR_W-1:0]   r_cur_step;
    logic [AREA_W-1:0]  r_cur_area;
    logic [AREA_W-1:0]  r_delta;
    logic               r_delta_mode;
    logic [STEP_W-1:0]  r_steps;
    logic               r_rd_inside;
    logic [AREA_W-1:0]  r_area;
    logic               r_status;

    // Memory ports.
    logic                      cell_we;
    logic [ADDR_W-1:0]         cell_raddr;
    logic [ELEV_W+DIR_W-1:0]   cell_rdata;
    logic                      area_we;
    logic [ADDR_W-1:0]         area_waddr;
    logic [AREA_W-1:0]         area_wdata;
    logic [ADDR_W-1:0]         area_raddr;
    logic [AREA_W-1:0]         area_rdata;

    logic                in_inside;
    logic [ADDR_W-1:0]   in_addr;
    logic [ADDR_W-1:0]   scan_addr;
    logic [ADDR_W-1:0]   nxt_addr_reg;
    logic [NR_W-1:0]     nr_sat;
    logic [NC_W-1:0]     nc_sat;
    logic [ELEV_W-1:0]   rd_elev;
    logic [DIR_W-1:0]    rd_step;
    logic                r_inc, r_dec, c_inc, c_dec;
    logic                off_grid;
    logic [ROW_W-1:0]    nxt_r;
    logic [COL_W-1:0]    nxt_c;
    logic                nxt_has_area;
    logic [AREA_W-1:0]   delta_sel;
    logic [AREA_W:0]     sum;
    logic [AREA_W-1:0]   upd_val;

    assign in_inside = (int'(i_row) < MAX_ROWS) && (int'(i_col) < MAX_COLS);
    assign in_addr   = cell_addr(ROW_W'(i_row), COL_W'(i_col));
    assign scan_addr = cell_addr(r_scan_r, r_scan_c);
    assign nxt_addr_reg = cell_addr(r_nxt_r, r_nxt_c);

    assign nr_sat = (int'(r_rows_used) > MAX_ROWS) ? NR_W'(MAX_ROWS) : NR_W'(r_rows_used);
    assign nc_sat = (int'(r_cols_used) > MAX_COLS) ? NC_W'(MAX_COLS) : NC_W'(r_cols_used);

    assign rd_elev = cell_rdata[ELEV_W+DIR_W-1:DIR_W];
    assign rd_step = cell_rdata[DIR_W-1:0];

    // Downstream cell of the current trace position.
    assign r_inc = (r_cur_step[DIR_W-1:OFS_W] == OFS_PLUS);
    assign r_dec = (r_cur_step[DIR_W-1:OFS_W] == OFS_MINUS);
    assign c_inc = (r_cur_step[OFS_W-1:0] == OFS_PLUS);
    assign c_dec = (r_cur_step[OFS_W-1:0] == OFS_MINUS);

    assign off_grid = (r_dec && (r_cur_r == '0))
                   || (r_inc && ((NR_W'(r_cur_r) + NR_W'(1)) >= r_nr))
                   || (c_dec && (r_cur_c == '0))
                   || (c_inc && ((NC_W'(r_cur_c) + NC_W'(1)) >= r_nc));

    assign nxt_r = r_inc ? ROW_W'(r_cur_r + 1'b1) : (r_dec ? ROW_W'(r_cur_r - 1'b1) : r_cur_r);
    assign nxt_c = c_inc ? COL_W'(r_cur_c + 1'b1) : (c_dec ? COL_W'(r_cur_c - 1'b1) : r_cur_c);

    // Area of the downstream cell: extend a new cell, or push the delta on.
    assign nxt_has_area = (area_rdata != '0);
    assign delta_sel    = r_delta_mode ? r_delta : r_cur_area;
    assign sum = nxt_has_area ? ({1'b0, area_rdata} + {1'b0, delta_sel})
                              : ({1'b0, r_cur_area} + (AREA_W + 1)'(r_cell_area));
    assign upd_val = sum[AREA_W] ? '1 : sum[AREA_W-1:0];

    // Memory port selection.
    assign cell_we    = i_cmd.load && in_inside;
    assign cell_raddr = i_cmd.step_issue ? cell_addr(nxt_r, nxt_c) : scan_addr;

    always_comb begin
        area_we    = 1'b0;
        area_waddr = r_clr_addr;
        area_wdata = '0;
        if (i_cmd.clr) begin
            area_we = 1'b1;
        end else if (i_cmd.start) begin
            area_we    = 1'b1;
            area_waddr = scan_addr;
            area_wdata = AREA_W'(r_cell_area);
        end else if (i_cmd.upd) begin
            area_we    = 1'b1;
            area_waddr = nxt_addr_reg;
            area_wdata = upd_val;
        end
    end

    always_comb begin
        area_raddr = scan_addr;
        if (i_cmd.rd_issue) begin
            area_raddr = in_addr;
        end else if (i_cmd.step_issue) begin
            area_raddr = cell_addr(nxt_r, nxt_c);
        end
    end

    dac_ram #(
        .WIDTH (ELEV_W + DIR_W),
        .DEPTH (NCELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (in_addr),
        .i_wdata ({i_elevation, i_step_row, i_step_col}),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    dac_ram #(
        .WIDTH (AREA_W),
        .DEPTH (NCELLS)
    ) u_area_ram (
        .i_clk   (i_clk),
        .i_we    (area_we),
        .i_waddr (area_waddr),
        .i_wdata (area_wdata),
        .i_raddr (area_raddr),
        .o_rdata (area_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_area <= CAREA_W'(1);
            r_rows_used <= DIM_W'(64);
            r_cols_used <= DIM_W'(64);
            r_cycle     <= 1'b0;
            r_ran       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CELL_AREA: r_cell_area <= i_cfg_data[CAREA_W-1:0];
                    CFG_ROWS_USED: r_rows_used <= i_cfg_data[DIM_W-1:0];
                    CFG_COLS_USED: r_cols_used <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.run_start) begin
                r_cycle <= 1'b0;
                r_ran   <= 1'b1;
            end else if (i_cmd.set_cycle) begin
                r_cycle <= 1'b1;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_nr       <= nr_sat;
            r_nc       <= nc_sat;
            r_limit    <= STEP_W'(STEP_W'(nr_sat) * STEP_W'(nc_sat));
            r_clr_addr <= '0;
            r_scan_r   <= ROW_W'(1);
            r_scan_c   <= COL_W'(1);
        end
        if (i_cmd.clr) begin
            r_clr_addr <= ADDR_W'(r_clr_addr + 1'b1);
        end
        if (i_cmd.advance) begin
            if (NR_W'(r_scan_r) == (r_nr - NR_W'(2))) begin
                r_scan_r <= ROW_W'(1);
                r_scan_c <= COL_W'(r_scan_c + 1'b1);
            end else begin
                r_scan_r <= ROW_W'(r_scan_r + 1'b1);
            end
        end
        if (i_cmd.scan_issue) begin
            r_cur_r <= r_scan_r;
            r_cur_c <= r_scan_c;
        end
        if (i_cmd.start) begin
            r_cur_area   <= AREA_W'(r_cell_area);
            r_cur_step   <= rd_step;
            r_steps      <= '0;
            r_delta_mode <= 1'b0;
        end
        if (i_cmd.step_issue) begin
            r_nxt_r <= nxt_r;
            r_nxt_c <= nxt_c;
        end
        if (i_cmd.upd) begin
            r_cur_r    <= r_nxt_r;
            r_cur_c    <= r_nxt_c;
            r_cur_area <= upd_val;
            r_cur_step <= rd_step;
            r_steps    <= STEP_W'(r_steps + 1'b1);
            if (nxt_has_area && !r_delta_mode) begin
                r_delta      <= r_cur_area;
                r_delta_mode <= 1'b1;
            end
        end
        if (i_cmd.rd_issue) begin
            r_rd_inside <= in_inside;
        end
        if (i_cmd.out_zero) begin
            r_area   <= '0;
            r_status <= r_cycle;
        end else if (i_cmd.out_rd) begin
            r_area   <= (r_rd_inside && r_ran) ? area_rdata : '0;
            r_status <= r_cycle;
        end
    end

    assign o_sts.clr_last   = (r_clr_addr == ADDR_W'(NCELLS - 1));
    assign o_sts.small_grid = (r_nr < NR_W'(3)) || (r_nc < NC_W'(3));
    assign o_sts.start_ok   = (rd_elev != '0) && (area_rdata == '0);
    assign o_sts.next_ok    = (r_inc || r_dec || c_inc || c_dec) && !off_grid;
    assign o_sts.nxt_sink   = (rd_elev == '0);
    assign o_sts.steps_full = (r_steps >= r_limit);
    assign o_sts.scan_last  = (NR_W'(r_scan_r) == (r_nr - NR_W'(2)))
                           && (NC_W'(r_scan_c) == (r_nc - NC_W'(2)));

    assign o_area   = r_area;
    assign o_status = r_status;

endmodule

>>> rtl/drained_area_accumulation_core.sv
// ============================================================================
// drained_area_accumulation_core : flow accumulation over a stored grid
// Holds per-cell elevation and downstream step, computes the drained area of
// every cell on request by tracing flow paths, and returns areas on read.
// ============================================================================
//
//   Channel  Direction  Handshake                Payload
//   -------  ---------  -----------------------  ---------------------------------
//   in       to core    i_in_valid / o_in_stall  func row col elevation step_*
//   out      from core  o_out_valid / i_out_stall area status
//   cfg      to core    i_cfg_we (no wait)       i_cfg_index i_cfg_data
//
// Loads stream at one per cycle while results are taken. A read goes through
// the read state, as the area memory has a registered read port. A run first
// clears the whole area memory, one entry a cycle, then visits each interior
// cell in the scan, start and advance states and passes through the step and
// update states for every downstream cell that a trace examines, all bound
// by the single read port of the area memory; the done state loads the
// result. Reset is synchronous and active low; it restores the configuration
// defaults and the cycle flag, the input stalls while reset is held, and
// reads before the first run return zero. The core takes no new transaction
// while a finished result is stalled and cannot be handed over in the same
// cycle.
//
// Every transaction returns exactly one result transaction. The area field
// holds the drained area for a read and zero otherwise; the status field
// reports whether the last run detected a cyclic flow path.
// ============================================================================
module drained_area_accumulation_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [dac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dac_pkg::CFG_W-1:0]         i_cfg_data,
    // Input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [dac_pkg::FUNC_W-1:0]        i_func,
    input  logic [dac_pkg::IDX_W-1:0]         i_row,
    input  logic [dac_pkg::IDX_W-1:0]         i_col,
    input  logic [dac_pkg::ELEV_W-1:0]        i_elevation,
    input  logic signed [dac_pkg::OFS_W-1:0]  i_step_row,
    input  logic signed [dac_pkg::OFS_W-1:0]  i_step_col,
    // Output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dac_pkg::AREA_W-1:0]        o_area,
    output logic                              o_status
);
    import dac_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller owns both handshakes and the sequencing of a run:
    // clearing sweep, scan over interior cells column by column, and the
    // trace loop that walks downstream steps.
    dac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the cell and area memories, the configuration, the
    // trace position and the saturating area arithmetic, and the output
    // payload register.
    dac_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_elevation (i_elevation),
        .i_step_row  (i_step_row),
        .i_step_col  (i_step_col),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_area      (o_area),
        .o_status    (o_status)
    );

endmodule
